// ===== rtl/core/packed_framebuffer_line_engine_top_defines.svh =====
// assertion macros for the framebuffer line engine
`ifndef PACKED_FRAMEBUFFER_LINE_ENGINE_TOP_DEFINES_SVH
`define PACKED_FRAMEBUFFER_LINE_ENGINE_TOP_DEFINES_SVH

// property checked on every clock edge outside reset
`define PFLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define PFLE_ASSERT_NEVER(lbl, cond, msg) \
  `PFLE_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/core/pfle_pkg.sv =====
package pfle_pkg;

  // signed coordinate wide enough for box insets and thick lines
  localparam int CoordW = 11;
  typedef logic signed [CoordW-1:0] coord_t;

  localparam logic [3:0] NibMask = 4'hF;

  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_PUT   = 3'd1;
  localparam logic [2:0] CMD_GET   = 3'd2;
  localparam logic [2:0] CMD_HLINE = 3'd3;
  localparam logic [2:0] CMD_VLINE = 3'd4;
  localparam logic [2:0] CMD_BOX   = 3'd5;

  typedef struct packed {
    logic [2:0] cmd;
    logic [8:0] x_start;
    logic [8:0] y_start;
    logic [8:0] x_end;
    logic [8:0] y_end;
    logic [3:0] color;
    logic [7:0] line_width;
  } req_t;

  typedef struct packed {
    logic [3:0] pixel_value;
    logic       out_of_range;
  } rsp_t;

endpackage

// ===== rtl/core/pfle_ram.sv =====
module pfle_ram #(
  parameter int DataW = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/packed_framebuffer_line_engine_top.sv =====
// steps: a request passes setup once per segment, then per pixel a range check and byte read,
//   plus a nibble merge and byte write for on-screen pixels, then done; clear sweeps the store
// throughput: one request at a time through the single byte ram read-modify-write loop;
//   the next request is taken the cycle after the result loads
// reset: control clears at once, then a clearing pass zeroes the store, one byte per cycle
//   (RowBytes*HEIGHT_PIX bytes, 38400 by default) while in_stall_o stays high
`include "packed_framebuffer_line_engine_top_defines.svh"

module packed_framebuffer_line_engine_top #(
  parameter int WIDTH_PIX  = 320,
  parameter int HEIGHT_PIX = 240
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pfle_pkg::req_t  in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pfle_pkg::rsp_t  out_rsp_o
);

  localparam int RowBytes   = (WIDTH_PIX + 1) / 2;
  localparam int StoreBytes = RowBytes * HEIGHT_PIX;
  localparam int AddrW      = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;

  localparam pfle_pkg::coord_t XLimit = pfle_pkg::coord_t'(WIDTH_PIX);
  localparam pfle_pkg::coord_t YLimit = pfle_pkg::coord_t'(HEIGHT_PIX);
  localparam pfle_pkg::coord_t One    = pfle_pkg::coord_t'(1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(StoreBytes - 1);

  // sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;  // sweep of the store writing zero
  localparam logic [2:0] ST_IDLE  = 3'd1;  // waiting for a request
  localparam logic [2:0] ST_SETUP = 3'd2;  // build the rectangle of one segment
  localparam logic [2:0] ST_PIX   = 3'd3;  // range check and byte read
  localparam logic [2:0] ST_RMW   = 3'd4;  // nibble merge and byte write
  localparam logic [2:0] ST_DONE  = 3'd5;  // hand the result to the output register

  logic [2:0]       state_q, state_d;
  pfle_pkg::req_t   req_q;
  logic [1:0]       seg_q, seg_d;
  pfle_pkg::coord_t x_q, x_d, y_q, y_d;
  pfle_pkg::coord_t x1_q, x1_d, y0_q, y0_d, y1_q, y1_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic             odd_q, odd_d;
  logic             flag_q, flag_d;
  logic [3:0]       pv_q, pv_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic             clr_cmd_q, clr_cmd_d;
  logic             out_valid_q, out_valid_d;
  pfle_pkg::rsp_t   out_q, out_d;

  // ram port
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  pfle_ram #(
    .DataW (8),
    .Depth (StoreBytes)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // segment geometry from the held request
  logic [7:0]       wm1;
  pfle_pkg::coord_t wm1_s, xs_s, ys_s, xe_s, ye_s, hline_y, vline_x;
  pfle_pkg::coord_t rx0, rx1, ry0, ry1;
  logic             is_box, is_pixel, is_hseg, seg_empty, last_seg;

  always_comb begin
    // a width of zero wraps to 255 here, so it acts as 256
    wm1      = req_q.line_width - 8'd1;
    wm1_s    = pfle_pkg::coord_t'({3'b000, wm1});
    xs_s     = pfle_pkg::coord_t'({2'b00, req_q.x_start});
    ys_s     = pfle_pkg::coord_t'({2'b00, req_q.y_start});
    xe_s     = pfle_pkg::coord_t'({2'b00, req_q.x_end});
    ye_s     = pfle_pkg::coord_t'({2'b00, req_q.y_end});
    is_box   = (req_q.cmd == pfle_pkg::CMD_BOX);
    is_pixel = (req_q.cmd == pfle_pkg::CMD_PUT) || (req_q.cmd == pfle_pkg::CMD_GET);
    // box order: top edge, bottom edge, right edge, left edge
    is_hseg  = (req_q.cmd == pfle_pkg::CMD_HLINE) || (is_box && !seg_q[1]);
    hline_y  = (is_box && (seg_q == 2'd1)) ? (ye_s - wm1_s) : ys_s;
    vline_x  = (is_box && (seg_q == 2'd2)) ? (xe_s - wm1_s) : xs_s;
    last_seg = !is_box || (seg_q == 2'd3);
    if (is_pixel) begin
      rx0       = xs_s;
      rx1       = xs_s;
      ry0       = ys_s;
      ry1       = ys_s;
      seg_empty = 1'b0;
    end else if (is_hseg) begin
      rx0       = xs_s;
      rx1       = xe_s;
      ry0       = hline_y;
      ry1       = hline_y + wm1_s;
      seg_empty = (xs_s > xe_s);
    end else begin
      rx0       = vline_x;
      rx1       = vline_x + wm1_s;
      ry0       = ys_s;
      ry1       = ye_s;
      seg_empty = (ys_s > ye_s);
    end
  end

  // current pixel: range check, byte address, nibble merge
  logic             on_screen, pix_last, col_last, out_free;
  logic [AddrW-1:0] pix_addr;
  logic [3:0]       cur_nib;
  logic [7:0]       merged;

  always_comb begin
    on_screen = !x_q[pfle_pkg::CoordW-1] && (x_q < XLimit) &&
                !y_q[pfle_pkg::CoordW-1] && (y_q < YLimit);
    pix_addr  = AddrW'(RowBytes) * AddrW'(y_q[8:0]) + AddrW'(x_q[8:1]);
    col_last  = (y_q == y1_q);
    pix_last  = col_last && (x_q == x1_q);
    cur_nib   = odd_q ? (ram_rdata[3:0] & pfle_pkg::NibMask)
                      : (ram_rdata[7:4] & pfle_pkg::NibMask);
    merged    = odd_q ? {ram_rdata[7:4], req_q.color} : {req_q.color, ram_rdata[3:0]};
    out_free  = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    state_d     = state_q;
    seg_d       = seg_q;
    x_d         = x_q;
    y_d         = y_q;
    x1_d        = x1_q;
    y0_d        = y0_q;
    y1_d        = y1_q;
    addr_d      = addr_q;
    odd_d       = odd_q;
    flag_d      = flag_q;
    pv_d        = pv_q;
    clr_d       = clr_q;
    clr_cmd_d   = clr_cmd_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = merged;
    ram_raddr   = pix_addr;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 8'h00;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == LastAddr) begin
          state_d   = clr_cmd_q ? ST_DONE : ST_IDLE;
          clr_cmd_d = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          seg_d  = 2'd0;
          flag_d = 1'b0;
          pv_d   = 4'd0;
          unique case (in_req_i.cmd) inside
            pfle_pkg::CMD_CLEAR: begin
              clr_d     = '0;
              clr_cmd_d = 1'b1;
              state_d   = ST_CLEAR;
            end
            pfle_pkg::CMD_PUT, pfle_pkg::CMD_GET, pfle_pkg::CMD_HLINE,
            pfle_pkg::CMD_VLINE, pfle_pkg::CMD_BOX: begin
              state_d = ST_SETUP;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_SETUP: begin
        if (seg_empty) begin
          if (last_seg) begin
            state_d = ST_DONE;
          end else begin
            seg_d = seg_q + 2'd1;
          end
        end else begin
          x_d     = rx0;
          y_d     = ry0;
          x1_d    = rx1;
          y0_d    = ry0;
          y1_d    = ry1;
          state_d = ST_PIX;
        end
      end
      ST_PIX, ST_RMW: begin
        if (state_q == ST_PIX && on_screen) begin
          // issue the byte read, merge next cycle
          addr_d  = pix_addr;
          odd_d   = x_q[0];
          state_d = ST_RMW;
        end else begin
          if (state_q == ST_PIX) begin
            flag_d = 1'b1;
          end else if (req_q.cmd == pfle_pkg::CMD_GET) begin
            pv_d = cur_nib;
          end else if (req_q.cmd == pfle_pkg::CMD_PUT || cur_nib == 4'd0) begin
            ram_we = 1'b1;
          end
          // column-major walk: rows inside, columns outside
          if (pix_last) begin
            if (last_seg) begin
              state_d = ST_DONE;
            end else begin
              seg_d   = seg_q + 2'd1;
              state_d = ST_SETUP;
            end
          end else begin
            state_d = ST_PIX;
            if (col_last) begin
              x_d = x_q + One;
              y_d = y0_q;
            end else begin
              y_d = y_q + One;
            end
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{pixel_value: pv_q, out_of_range: flag_q};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      clr_cmd_q   <= 1'b0;
      seg_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      clr_cmd_q   <= clr_cmd_d;
      seg_q       <= seg_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      req_q <= in_req_i;
    end
    x_q    <= x_d;
    y_q    <= y_d;
    x1_q   <= x1_d;
    y0_q   <= y0_d;
    y1_q   <= y1_d;
    addr_q <= addr_d;
    odd_q  <= odd_d;
    flag_q <= flag_d;
    pv_q   <= pv_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // no store write without a request in flight or a clearing pass
  `PFLE_ASSERT_NEVER(a_no_idle_write,
    ram_we && (state_q == ST_IDLE || state_q == ST_DONE),
    "store written while idle")
  // every write stays inside the store
  `PFLE_ASSERT(a_write_in_range,
    ram_we |-> (ram_waddr <= LastAddr),
    "store write address out of range")
  // an accepted request always leaves idle
  `PFLE_ASSERT(a_accept_leaves_idle,
    (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE),
    "request accepted but sequencer stayed idle")
  // a new result is only loaded when the previous one was taken
  `PFLE_ASSERT(a_no_result_overwrite,
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)),
    "pending result lost or changed")

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // screen geometry, kept equal to what the block is built with
  localparam int WidthPix    = 320;
  localparam int HeightPix   = 240;
  localparam int RowBytes    = (WidthPix + 1) / 2;
  localparam int StoreBytes  = RowBytes * HeightPix;
  localparam int CoordMax    = 511;

  // run length and limits
  localparam int NumRandom   = 1200;
  localparam int StuckLimit  = 200000;  // well past a full clear plus the longest stall
  localparam int DrainCycles = 50;

  // command codes the package leaves unnamed; the block answers them with zeros
  localparam logic [2:0] CMD_RSVD_LO = 3'd6;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_EVERY_THIRD} stall_mode_e;

  // shadow copy of the frame store plus the answers still owed by the block
  class frame_mirror;
    bit [7:0]       pix_bytes [StoreBytes];
    pfle_pkg::rsp_t answer_q [$];
    int             mismatch_cnt;
    bit             off_screen;

    function new();
      mismatch_cnt = 0;
    endfunction

    function bit on_screen(int x, int y);
      return x >= 0 && x < WidthPix && y >= 0 && y < HeightPix;
    endfunction

    // even columns live in the high nibble
    function logic [3:0] peek(int x, int y);
      bit [7:0] b;
      b = pix_bytes[y * RowBytes + x / 2];
      return (x % 2 == 0) ? b[7:4] : b[3:0];
    endfunction

    function void poke(int x, int y, logic [3:0] c);
      int idx;
      idx = y * RowBytes + x / 2;
      if (x % 2 == 0) pix_bytes[idx][7:4] = c;
      else pix_bytes[idx][3:0] = c;
    endfunction

    // line drawing only paints pixels that are still blank
    function void fill_blank(int x0, int x1, int y0, int y1, logic [3:0] c);
      for (int x = x0; x <= x1; x++)
        for (int y = y0; y <= y1; y++)
          if (!on_screen(x, y)) off_screen = 1'b1;
          else if (peek(x, y) == 4'h0) poke(x, y, c);
    endfunction

    function void hspan(int xl, int xr, int y, logic [3:0] c, int w);
      if (xl <= xr) fill_blank(xl, xr, y, y + w - 1, c);
    endfunction

    function void vspan(int yu, int yd, int x, logic [3:0] c, int w);
      if (yu <= yd) fill_blank(x, x + w - 1, yu, yd, c);
    endfunction

    function void apply_request(pfle_pkg::req_t r);
      int             xs, ys, xe, ye, w;
      pfle_pkg::rsp_t ans;
      xs = int'(r.x_start);
      ys = int'(r.y_start);
      xe = int'(r.x_end);
      ye = int'(r.y_end);
      w  = (r.line_width == 8'd0) ? 256 : int'(r.line_width);
      off_screen = 1'b0;
      ans = '0;
      case (r.cmd)
        pfle_pkg::CMD_CLEAR: foreach (pix_bytes[i]) pix_bytes[i] = 8'h00;
        pfle_pkg::CMD_PUT: begin
          if (on_screen(xs, ys)) poke(xs, ys, r.color);
          else off_screen = 1'b1;
        end
        pfle_pkg::CMD_GET: begin
          if (on_screen(xs, ys)) ans.pixel_value = peek(xs, ys);
          else off_screen = 1'b1;
        end
        pfle_pkg::CMD_HLINE: hspan(xs, xe, ys, r.color, w);
        pfle_pkg::CMD_VLINE: vspan(ys, ye, xs, r.color, w);
        pfle_pkg::CMD_BOX: begin
          hspan(xs, xe, ys, r.color, w);
          hspan(xs, xe, ye - w + 1, r.color, w);
          vspan(ys, ye, xe - w + 1, r.color, w);
          vspan(ys, ye, xs, r.color, w);
        end
        default: ;
      endcase
      ans.out_of_range = off_screen;
      answer_q.push_back(ans);
    endfunction

    function void check_response(pfle_pkg::rsp_t got);
      pfle_pkg::rsp_t want;
      if (answer_q.size() == 0) begin
        $error("response with no request outstanding: pixel_value %0d out_of_range %0d",
               got.pixel_value, got.out_of_range);
        mismatch_cnt++;
        return;
      end
      want = answer_q.pop_front();
      if (got.pixel_value !== want.pixel_value) begin
        $error("pixel_value: expected %0d, actual %0d", want.pixel_value, got.pixel_value);
        mismatch_cnt++;
      end
      if (got.out_of_range !== want.out_of_range) begin
        $error("out_of_range: expected %0d, actual %0d", want.out_of_range, got.out_of_range);
        mismatch_cnt++;
      end
    endfunction

    function int pending();
      return answer_q.size();
    endfunction
  endclass

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  pfle_pkg::req_t in_req    = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  pfle_pkg::rsp_t out_rsp;

  frame_mirror sb = new();
  int          owed = 0;          // answers outstanding as of the previous edge
  int          stuck_cycles = 0;  // cycles in a row with no handshake on either side
  int          burst_left = 0;
  int          hot_x = 0;
  int          hot_y = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;

  packed_framebuffer_line_engine_top #(
    .WIDTH_PIX (WidthPix),
    .HEIGHT_PIX(HeightPix)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure: segments of random length, each with its own pattern
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(10, 120);
      out_stall  <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        STALL_NONE:        out_stall <= 1'b0;
        STALL_LIGHT:       out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:       out_stall <= ($urandom_range(0, 3) != 0);
        STALL_EVERY_THIRD: out_stall <= (stall_left % 3 == 0);
      endcase
    end
  end

  // monitor: values read here are the ones the block saw at this edge
  // results are checked before the request of the same edge is noted,
  // so a stray result can never consume a fresh expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_response(out_rsp);
      if (in_valid && !in_stall) sb.apply_request(in_req);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      owed <= sb.pending();
      // watchdog: no handshake for too long means the block is hung
      if (stuck_cycles >= StuckLimit) begin
        $display("packed_framebuffer_line_engine_top test failed");
        $finish;
      end
    end
  end

  // send one request; bursts of random length separated by random gaps
  task automatic push_request(input pfle_pkg::req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(20, 60);
      else gap = $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off the sender until every answer is in
  task automatic wait_for_answers();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed != 0);
  endtask

  function automatic pfle_pkg::req_t make_req(logic [2:0] cmd, int xs, int ys, int xe,
                                              int ye, int color, int w);
    pfle_pkg::req_t r;
    r.cmd        = cmd;
    r.x_start    = 9'(xs);
    r.y_start    = 9'(ys);
    r.x_end      = 9'(xe);
    r.y_end      = 9'(ye);
    r.color      = 4'(color);
    r.line_width = 8'(w);
    return r;
  endfunction

  // mostly near a hot window so reads land on drawn pixels, some anywhere,
  // some straddling the screen edge
  function automatic int pick_coord(int hot, int screen_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return hot + $urandom_range(0, 15);
    if (r < 85) return $urandom_range(0, screen_max - 1);
    if (r < 93) return screen_max - 4 + $urandom_range(0, 7);
    return $urandom_range(0, CoordMax);
  endfunction

  function automatic logic [8:0] span_end(int s, int len);
    return (s + len > CoordMax) ? 9'(CoordMax) : 9'(s + len);
  endfunction

  function automatic pfle_pkg::req_t random_request();
    pfle_pkg::req_t r;
    int             roll, shape, xs, ys;
    roll  = $urandom_range(0, 999);
    shape = $urandom_range(0, 99);
    xs    = pick_coord(hot_x, WidthPix);
    ys    = pick_coord(hot_y, HeightPix);
    r.cmd        = pfle_pkg::CMD_PUT;
    r.x_start    = 9'(xs);
    r.y_start    = 9'(ys);
    r.x_end      = 9'($urandom);
    r.y_end      = 9'($urandom);
    r.color      = 4'($urandom);
    r.line_width = 8'($urandom_range(1, 4));
    if (roll < 3) r.cmd = pfle_pkg::CMD_CLEAR;
    else if (roll < 12) begin
      // unused codes with arbitrary fields
      r.cmd        = ($urandom_range(0, 1) == 0) ? CMD_RSVD_LO : CMD_RSVD_HI;
      r.line_width = 8'($urandom);
    end else if (roll < 330) r.cmd = pfle_pkg::CMD_PUT;
    else if (roll < 600) r.cmd = pfle_pkg::CMD_GET;
    else begin
      if (roll < 760) r.cmd = pfle_pkg::CMD_HLINE;
      else if (roll < 900) r.cmd = pfle_pkg::CMD_VLINE;
      else r.cmd = pfle_pkg::CMD_BOX;
      // short spans keep the pixel count, and so the run time, small
      if (r.cmd != pfle_pkg::CMD_VLINE) r.x_end = span_end(xs, $urandom_range(0, 40));
      if (r.cmd != pfle_pkg::CMD_HLINE) r.y_end = span_end(ys, $urandom_range(0, 30));
      if (shape < 8) begin
        // thick line over a tiny span, reaches the top bits of the width
        r.line_width = 8'($urandom);
        if (r.cmd != pfle_pkg::CMD_VLINE) r.x_end = span_end(xs, $urandom_range(0, 2));
        if (r.cmd != pfle_pkg::CMD_HLINE) r.y_end = span_end(ys, $urandom_range(0, 2));
      end else if (shape < 16) begin
        // start past the end
        if (xs > 0) r.x_end = 9'($urandom_range(0, xs - 1));
        if (ys > 0) r.y_end = 9'($urandom_range(0, ys - 1));
      end
    end
    return r;
  endfunction

  task automatic run_directed();
    pfle_pkg::req_t plan [$];
    // pixel access, both nibbles, far corner
    plan.push_back(make_req(pfle_pkg::CMD_GET, 0, 0, 0, 0, 0, 1));
    plan.push_back(make_req(pfle_pkg::CMD_PUT, 0, 0, 0, 0, 15, 1));
    plan.push_back(make_req(pfle_pkg::CMD_PUT, 1, 0, 0, 0, 5, 1));
    plan.push_back(make_req(pfle_pkg::CMD_GET, 0, 0, 0, 0, 0, 1));
    plan.push_back(make_req(pfle_pkg::CMD_GET, 1, 0, 0, 0, 0, 1));
    plan.push_back(make_req(pfle_pkg::CMD_PUT, WidthPix - 1, HeightPix - 1, 0, 0, 10, 1));
    plan.push_back(make_req(pfle_pkg::CMD_GET, WidthPix - 1, HeightPix - 1, 0, 0, 0, 1));
    // off screen by column, by row, and all-ones fields
    plan.push_back(make_req(pfle_pkg::CMD_PUT, WidthPix, 0, 0, 0, 3, 1));
    plan.push_back(make_req(pfle_pkg::CMD_PUT, 0, HeightPix, 0, 0, 3, 1));
    plan.push_back(make_req(pfle_pkg::CMD_GET, CoordMax, CoordMax, CoordMax, CoordMax, 15, 255));
    // second line over the first only fills what is still blank
    plan.push_back(make_req(pfle_pkg::CMD_HLINE, 2, 2, 10, 0, 3, 1));
    plan.push_back(make_req(pfle_pkg::CMD_HLINE, 2, 2, 10, 0, 9, 2));
    plan.push_back(make_req(pfle_pkg::CMD_GET, 5, 2, 0, 0, 0, 1));
    plan.push_back(make_req(pfle_pkg::CMD_GET, 5, 3, 0, 0, 0, 1));
    plan.push_back(make_req(pfle_pkg::CMD_VLINE, 20, 5, 0, 15, 7, 3));
    plan.push_back(make_req(pfle_pkg::CMD_BOX, 40, 40, 60, 60, 12, 2));
    plan.push_back(make_req(pfle_pkg::CMD_GET, 41, 50, 0, 0, 0, 1));
    // width zero means 256 rows, running off the bottom
    plan.push_back(make_req(pfle_pkg::CMD_HLINE, 100, 0, 100, 0, 6, 0));
    // widest line running off the right side
    plan.push_back(make_req(pfle_pkg::CMD_VLINE, 300, 100, 0, 100, 2, 255));
    // box thicker than itself, insets go negative
    plan.push_back(make_req(pfle_pkg::CMD_BOX, 0, 0, 5, 5, 4, 10));
    // empty spans
    plan.push_back(make_req(pfle_pkg::CMD_HLINE, 50, 30, 40, 0, 1, 3));
    plan.push_back(make_req(pfle_pkg::CMD_VLINE, 30, 50, 0, 40, 1, 3));
    // color zero still flags the off-screen part
    plan.push_back(make_req(pfle_pkg::CMD_HLINE, WidthPix - 10, 5, WidthPix + 10, 0, 0, 1));
    plan.push_back(make_req(CMD_RSVD_LO, CoordMax, CoordMax, CoordMax, CoordMax, 15, 255));
    plan.push_back(make_req(CMD_RSVD_HI, CoordMax, CoordMax, CoordMax, CoordMax, 15, 255));
    plan.push_back(make_req(pfle_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 1));
    plan.push_back(make_req(pfle_pkg::CMD_GET, 0, 0, 0, 0, 0, 1));
    foreach (plan[i]) push_request(plan[i]);
  endtask

  // stimulus: reset once, directed requests, then random ones
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // block runs its clearing pass with the request side stalled
    run_directed();
    wait_for_answers();
    for (int n = 0; n < NumRandom; n++) begin
      if (n % 100 == 0) begin
        hot_x = $urandom_range(0, WidthPix - 8);
        hot_y = $urandom_range(0, HeightPix - 8);
      end
      if (n == NumRandom / 2 || $urandom_range(0, 299) == 0) wait_for_answers();
      push_request(random_request());
    end
    wait_for_answers();
    // drain, to catch a stray extra result
    repeat (DrainCycles) @(posedge clk);
    if (sb.mismatch_cnt == 0 && sb.pending() == 0) begin
      $display("packed_framebuffer_line_engine_top test passed");
    end else begin
      $display("packed_framebuffer_line_engine_top test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/pfle_pkg.sv
rtl/core/pfle_ram.sv
rtl/core/packed_framebuffer_line_engine_top.sv
verif/testbench.sv
